// ===== sv/csic_pkg.sv =====
// Shared types, codes and an arithmetic helper for the chi-squared block.
package csic_pkg;

    // Input kinds carried on s_tuser
    localparam logic OP_MATRIX = 1'b0;
    localparam logic OP_BIN    = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] CFG_DIAGONAL_ONLY = 8'd0;
    localparam logic [7:0] CFG_BIN_COUNT     = 8'd1;

    localparam logic [5:0] BIN_COUNT_RESET = 6'd14;

    // Stream widths
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic res_write;
        logic rd_ri;
        logic ri_latch;
        logic sq;
        logic rd_j;
        logic j_mul;
        logic j_acc;
        logic mul_lo;
        logic mul_hi;
        logic mul_sum;
        logic term_add;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic bin_take;
        logic div_done;
        logic bin_last;
        logic diag;
        logic j_last;
        logic i_last;
        logic out_free;
    } stat_t;

    // Saturating signed add; bit 64 flags saturation
    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [63:0] s;
        logic               o;
        s = a + b;
        o = (a[63] == b[63]) && (s[63] != a[63]);
        if (o) begin
            return {1'b1, (a[63] ? S64_MIN : S64_MAX)};
        end
        return {1'b0, s};
    endfunction

endpackage

// ===== sv/csic_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module csic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word and read one word; the read data is registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/csic_ctrl.sv =====
// Controller state machine sequencing division and chi-squared evaluation.
module csic_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  csic_pkg::stat_t stat,
    output csic_pkg::cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DIV     = 4'd1;
    localparam logic [3:0] ST_RES     = 4'd2;
    localparam logic [3:0] ST_RI_RD   = 4'd3;
    localparam logic [3:0] ST_RI_WAIT = 4'd4;
    localparam logic [3:0] ST_SQ      = 4'd5;
    localparam logic [3:0] ST_J_RD    = 4'd6;
    localparam logic [3:0] ST_J_WAIT  = 4'd7;
    localparam logic [3:0] ST_J_ACC   = 4'd8;
    localparam logic [3:0] ST_MUL_LO  = 4'd9;
    localparam logic [3:0] ST_MUL_HI  = 4'd10;
    localparam logic [3:0] ST_MUL_SUM = 4'd11;
    localparam logic [3:0] ST_TERM    = 4'd12;
    localparam logic [3:0] ST_FIN     = 4'd13;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid && stat.bin_take) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                cmd.res_write = 1'b1;
                state_next    = stat.bin_last ? ST_RI_RD : ST_IDLE;
            end
            ST_RI_RD: begin
                cmd.rd_ri  = 1'b1;
                state_next = ST_RI_WAIT;
            end
            ST_RI_WAIT: begin
                cmd.ri_latch = 1'b1;
                state_next   = stat.diag ? ST_SQ : ST_J_RD;
            end
            ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_TERM;
            end
            ST_J_RD: begin
                cmd.rd_j   = 1'b1;
                state_next = ST_J_WAIT;
            end
            ST_J_WAIT: begin
                cmd.j_mul  = 1'b1;
                state_next = ST_J_ACC;
            end
            ST_J_ACC: begin
                cmd.j_acc  = 1'b1;
                state_next = stat.j_last ? ST_MUL_LO : ST_J_RD;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_SUM;
            end
            ST_MUL_SUM: begin
                cmd.mul_sum = 1'b1;
                state_next  = ST_TERM;
            end
            ST_TERM: begin
                cmd.term_add = 1'b1;
                state_next   = stat.i_last ? ST_FIN : ST_RI_RD;
            end
            ST_FIN: begin
                // Hold until the output register is free
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/csic_dp.sv =====
// Datapath: residual divider, stores, multiply-accumulate and output register.
module csic_dp #(
    parameter int MAX_BINS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [7:0]                         cfg_addr,
    input  logic [7:0]                         cfg_data,
    input  logic [csic_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [csic_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [csic_pkg::M_TUSER_W-1:0]     m_tuser,
    input  csic_pkg::cmd_t                     cmd,
    output csic_pkg::stat_t                    stat
);

    localparam int IW        = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int AW        = (MAX_BINS > 1) ? $clog2(MAX_BINS * MAX_BINS) : 1;
    localparam int BIN_LIMIT = (MAX_BINS < 32) ? MAX_BINS : 32;
    localparam int DW        = 33 + FRAC_BITS;
    localparam int CW        = $clog2(DW);
    localparam int UBW       = 64 - FRAC_BITS;
    localparam int LOW       = UBW / 2;
    localparam int HIW       = UBW - LOW;
    localparam int PW        = 32 + UBW;

    // Unpack the input transaction
    logic               in_op;
    logic [4:0]         in_row, in_col;
    logic signed [31:0] in_mat, in_obs, in_mod;
    logic [30:0]        in_sig;

    assign in_op  = s_tuser[0];
    assign in_row = s_tdata[4:0];
    assign in_col = s_tdata[9:5];
    assign in_mat = s_tdata[41:10];
    assign in_obs = s_tdata[73:42];
    assign in_mod = s_tdata[105:74];
    assign in_sig = s_tdata[136:106];

    // Configuration registers
    logic       diag_reg;
    logic [5:0] bin_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diag_reg      <= 1'b0;
            bin_count_reg <= csic_pkg::BIN_COUNT_RESET;
        end else if (cfg_valid) begin
            if (cfg_addr == csic_pkg::CFG_DIAGONAL_ONLY) begin
                diag_reg <= cfg_data[0];
            end else if (cfg_addr == csic_pkg::CFG_BIN_COUNT) begin
                bin_count_reg <= cfg_data[5:0];
            end
        end
    end

    // Clamp the bin count to the supported range
    logic [5:0] n_eff;
    always_comb begin
        if (bin_count_reg == 6'd0) begin
            n_eff = 6'd1;
        end else if (bin_count_reg > 6'(BIN_LIMIT)) begin
            n_eff = 6'(BIN_LIMIT);
        end else begin
            n_eff = bin_count_reg;
        end
    end

    logic bin_ok, in_last;
    assign bin_ok  = ({1'b0, in_row} < n_eff);
    assign in_last = ({1'b0, in_row} == (n_eff - 6'd1));

    // Matrix store write, dropping out-of-range indexes
    logic          mat_we;
    logic [AW-1:0] mat_waddr, mat_raddr;
    logic [31:0]   mat_rdata;

    assign mat_we = cmd.accept && (in_op == csic_pkg::OP_MATRIX)
                    && ({27'd0, in_row} < 32'(MAX_BINS))
                    && ({27'd0, in_col} < 32'(MAX_BINS));
    assign mat_waddr = AW'(AW'(in_row) * AW'(MAX_BINS) + AW'(in_col));

    // Divider and residual registers
    logic [DW-1:0] sreg_reg;
    logic [30:0]   rem_reg, sig_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg, sigz_reg, bin_last_reg;
    logic [4:0]    bin_row_reg;

    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [31:0]        trial;
    logic               trial_ge;

    assign diff     = {in_obs[31], in_obs} - {in_mod[31], in_mod};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign trial    = {rem_reg, sreg_reg[DW-1]};
    assign trial_ge = (trial >= {1'b0, sig_reg});

    // Saturate and sign the quotient
    logic [DW-1:0] q_lim;
    logic          q_gt;
    logic [31:0]   q_sat, res_val;

    assign q_lim = neg_reg ? DW'(33'h0_8000_0000) : DW'(33'h0_7FFF_FFFF);
    assign q_gt  = (sreg_reg > q_lim);
    assign q_sat = q_gt ? q_lim[31:0] : sreg_reg[31:0];
    always_comb begin
        if (sigz_reg) begin
            res_val = 32'd0;
        end else if (neg_reg) begin
            res_val = 32'(-q_sat);
        end else begin
            res_val = q_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && stat.bin_take) begin
            sreg_reg     <= DW'({diff_mag, {FRAC_BITS{1'b0}}});
            rem_reg      <= '0;
            cnt_reg      <= '0;
            sig_reg      <= in_sig;
            neg_reg      <= diff[32];
            sigz_reg     <= (in_sig == 31'd0);
            bin_row_reg  <= in_row;
            bin_last_reg <= in_last;
        end else if (cmd.div_step) begin
            sreg_reg <= {sreg_reg[DW-2:0], trial_ge};
            rem_reg  <= trial_ge ? 31'(trial - {1'b0, sig_reg}) : trial[30:0];
            cnt_reg  <= cnt_reg + CW'(1);
        end
    end

    // Residual store
    logic          res_we;
    logic [IW-1:0] res_raddr;
    logic [31:0]   res_rdata;
    logic [4:0]    i_reg, j_reg;

    assign res_we    = cmd.res_write;
    assign res_raddr = cmd.rd_ri ? IW'(i_reg) : IW'(j_reg);
    assign mat_raddr = AW'(AW'(i_reg) * AW'(MAX_BINS) + AW'(j_reg));

    csic_ram #(.WIDTH(32), .DEPTH(MAX_BINS * MAX_BINS), .AW(AW)) u_mat_ram (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (in_mat),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    csic_ram #(.WIDTH(32), .DEPTH(MAX_BINS), .AW(IW)) u_res_ram (
        .aclk  (aclk),
        .we    (res_we),
        .waddr (IW'(bin_row_reg)),
        .wdata (res_val),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    // Evaluation registers
    logic signed [31:0]  ri_reg;
    logic signed [63:0]  prod_reg, acc_reg, term_reg, chi_reg;
    logic [32+LOW-1:0]   pplo_reg;
    logic [32+HIW-1:0]   pphi_reg;
    logic                zs_reg, ovf_reg;

    // Magnitudes for the row-sum product
    logic [63:0]  acc_mag;
    logic [UBW-1:0] ub;
    logic [31:0]  ua;
    logic         mneg;
    logic [PW-1:0] p_full, p_lim;
    logic         p_gt;
    logic [64:0]  acc_sum, chi_sum;

    assign acc_mag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign ub      = acc_mag[63:FRAC_BITS];
    assign ua      = ri_reg[31] ? 32'(-ri_reg) : 32'(ri_reg);
    assign mneg    = ri_reg[31] ^ acc_reg[63];
    assign p_full  = PW'({pphi_reg, {LOW{1'b0}}}) + PW'(pplo_reg);
    assign p_lim   = mneg ? PW'(64'h8000_0000_0000_0000) : PW'(64'h7FFF_FFFF_FFFF_FFFF);
    assign p_gt    = (p_full > p_lim);
    assign acc_sum = csic_pkg::sat_add(acc_reg, prod_reg);
    assign chi_sum = csic_pkg::sat_add(chi_reg, term_reg);

    always_ff @(posedge aclk) begin
        if (cmd.res_write && bin_last_reg) begin
            i_reg   <= '0;
            chi_reg <= '0;
        end
        if (cmd.ri_latch) begin
            ri_reg  <= res_rdata;
            j_reg   <= '0;
            acc_reg <= '0;
        end
        if (cmd.sq) begin
            term_reg <= ri_reg * ri_reg;
        end
        if (cmd.j_mul) begin
            prod_reg <= $signed(mat_rdata) * $signed(res_rdata);
        end
        if (cmd.j_acc) begin
            acc_reg <= acc_sum[63:0];
            j_reg   <= j_reg + 5'd1;
        end
        if (cmd.mul_lo) begin
            pplo_reg <= ua * ub[LOW-1:0];
        end
        if (cmd.mul_hi) begin
            pphi_reg <= ua * ub[UBW-1:LOW];
        end
        if (cmd.mul_sum) begin
            if (p_gt) begin
                term_reg <= mneg ? csic_pkg::S64_MIN : csic_pkg::S64_MAX;
            end else if (mneg) begin
                term_reg <= 64'(-p_full[63:0]);
            end else begin
                term_reg <= p_full[63:0];
            end
        end
        if (cmd.term_add) begin
            chi_reg <= chi_sum[63:0];
            i_reg   <= i_reg + 5'd1;
        end
        if (cmd.out_load) begin
            m_tdata <= chi_reg;
            m_tuser <= {ovf_reg, zs_reg};
        end
    end

    // Sticky flags and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zs_reg   <= 1'b0;
            ovf_reg  <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                zs_reg  <= 1'b0;
                ovf_reg <= 1'b0;
            end else begin
                if (cmd.res_write) begin
                    zs_reg  <= zs_reg | sigz_reg;
                    ovf_reg <= ovf_reg | (!sigz_reg && q_gt);
                end
                if (cmd.j_acc) begin
                    ovf_reg <= ovf_reg | acc_sum[64];
                end
                if (cmd.mul_sum) begin
                    ovf_reg <= ovf_reg | p_gt;
                end
                if (cmd.term_add) begin
                    ovf_reg <= ovf_reg | chi_sum[64];
                end
            end
            if (cmd.out_load) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // Status back to the controller
    always_comb begin
        stat          = '0;
        stat.bin_take = (in_op == csic_pkg::OP_BIN) && bin_ok;
        stat.div_done = (cnt_reg == CW'(DW - 1));
        stat.bin_last = bin_last_reg;
        stat.diag     = diag_reg;
        stat.j_last   = ({1'b0, j_reg} == (n_eff - 6'd1));
        stat.i_last   = ({1'b0, i_reg} == (n_eff - 6'd1));
        stat.out_free = !m_tvalid || m_tready;
    end

endmodule

// ===== sv/chi_squared_inverse_covariance.sv =====
// Top level: chi-squared against an inverse covariance matrix, Q16.16 in, Q32.32 out.
//
//  channel  dir  fields
//  s_       in   tuser: op; tdata: row, col, matrix, observed, model, sigma
//  m_       out  tdata: chi_squared; tuser: zero_sigma, overflowed
//  cfg_     in   addr 0 diagonal_only, addr 1 bin_count
//
// A matrix write does not stall the input. A bin runs through the one-bit-per-cycle
// restoring divider. The last bin then adds the evaluation over all bins in full mode,
// or over the diagonal only in diagonal mode, paced by the single read ports of the stores.
// Reset is synchronous, active low; the stores need no clearing pass.
// A finished result waits in the output register; input is taken meanwhile.
module chi_squared_inverse_covariance #(
    parameter int MAX_BINS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [7:0]                     cfg_addr,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row[4:0], col[9:5], matrix[41:10], observed[73:42], model[105:74], sigma[136:106]
    input  logic [csic_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // chi_squared[63:0]
    output logic [csic_pkg::M_TDATA_W-1:0] m_tdata,
    // zero_sigma[0], overflowed[1]
    output logic [csic_pkg::M_TUSER_W-1:0] m_tuser
);

    csic_pkg::cmd_t  cmd;
    csic_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    csic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csic_dp #(.MAX_BINS(MAX_BINS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== sv/csic_checker.sv =====
// Port-level checks for the chi-squared block, bound to the top level.
module csic_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [0:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [csic_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [csic_pkg::M_TUSER_W-1:0] m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // A new result comes with the block back to idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while busy");

    // A matrix write never stalls the input
    a_matrix_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == csic_pkg::OP_MATRIX) |=> s_tready)
        else $error("matrix write stalled input");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration stalled");

endmodule

bind chi_squared_inverse_covariance csic_checker u_csic_checker (.*);
